/* rtl/core/itr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, constants and helpers for the integer to radix string block.
// ----------------------------------------------------------------------------
package itr_pkg;

	localparam int MAX_RADIX_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	// bits of the magnitude consumed per divide cycle
	localparam int DIV_STEP = 8;

	localparam int RADIX_W = 5;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [7:0] MINUS_SIGN = 8'h2D;

	localparam logic [RADIX_W-1:0] RADIX_RST   = RADIX_W'(10);
	localparam logic [31:0]        SYM0_RST    = 32'h3332_3130;
	localparam logic [31:0]        SYM1_RST    = 32'h3736_3534;
	localparam logic [31:0]        SYM2_RST    = 32'h6261_3938;
	localparam logic [31:0]        SYM3_RST    = 32'h6665_6463;

	// register index (paddr[4:2])
	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_SYM0  = 3'd1;
	localparam logic [2:0] REG_SYM1  = 3'd2;
	localparam logic [2:0] REG_SYM2  = 3'd3;
	localparam logic [2:0] REG_SYM3  = 3'd4;

	typedef logic [3:0][31:0] sym_tab_t;

	typedef struct packed {
		logic load;
		logic step;
		logic push;
		logic emit_sign;
		logic emit_digit;
	} itr_cmd_t;

	typedef struct packed {
		logic quot_zero;
		logic neg;
		logic last_digit;
		logic out_free;
	} itr_status_t;

	function automatic logic [7:0] sym_of(input sym_tab_t tab, input logic [3:0] idx);
		return tab[idx[3:2]][{idx[1:0], 3'b000} +: 8];
	endfunction

endpackage

/* rtl/core/itr_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_regs
// APB configuration registers: radix and the sixteen digit symbols.
// ----------------------------------------------------------------------------
module itr_regs
	import itr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [RADIX_W-1:0] radix,
	output sym_tab_t           symbols
);

	logic [RADIX_W-1:0] radix_q;
	sym_tab_t           sym_q;
	logic               wr_en;
	logic [2:0]         idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RST;
			sym_q[0] <= SYM0_RST;
			sym_q[1] <= SYM1_RST;
			sym_q[2] <= SYM2_RST;
			sym_q[3] <= SYM3_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RADIX: radix_q  <= pwdata[RADIX_W-1:0];
				REG_SYM0:  sym_q[0] <= pwdata;
				REG_SYM1:  sym_q[1] <= pwdata;
				REG_SYM2:  sym_q[2] <= pwdata;
				REG_SYM3:  sym_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RADIX: prdata = PDATA_W'(radix_q);
			REG_SYM0:  prdata = sym_q[0];
			REG_SYM1:  prdata = sym_q[1];
			REG_SYM2:  prdata = sym_q[2];
			REG_SYM3:  prdata = sym_q[3];
			default:   prdata = '0;
		endcase
	end

	assign radix   = radix_q;
	assign symbols = sym_q;

endmodule

/* rtl/core/itr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_dp
// Datapath: magnitude, chunked long division by the radix, digit stack and
// output register.
// ----------------------------------------------------------------------------
module itr_dp
	import itr_pkg::*;
#(
	parameter int MAX_RADIX  = MAX_RADIX_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  itr_cmd_t                     cmd,
	output itr_status_t                  status,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]           radix,
	input  sym_tab_t                     symbols,
	output logic [7:0]                   character,
	output logic                         last,
	output logic                         result_valid,
	input  logic                         result_ready
);

	localparam int N_CHUNK = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int MAG_W   = N_CHUNK * DIV_STEP;
	localparam int REM_W   = $clog2(MAX_RADIX);
	localparam int TRY_W   = REM_W + 1;
	localparam int CMP_W   = (RADIX_W > TRY_W) ? RADIX_W : TRY_W;
	localparam int CNT_W   = $clog2(VALUE_BITS + 1);

	logic [MAG_W-1:0]      mag_q;
	logic [REM_W-1:0]      rem_q;
	logic [TRY_W-1:0]      eff_q;
	logic                  neg_q;
	logic [REM_W-1:0]      dig_q [VALUE_BITS];
	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  valid_q;

	logic [VALUE_BITS-1:0] abs_val;
	logic [CMP_W-1:0]      rad_ext;
	logic [CMP_W-1:0]      rad_clamp;
	logic [MAG_W-1:0]      mag_nxt;
	logic [REM_W-1:0]      rem_nxt;
	logic [REM_W+3:0]      dig_ext;
	logic                  out_free;

	assign abs_val = value[VALUE_BITS-1] ? VALUE_BITS'(-value) : VALUE_BITS'(value);
	assign rad_ext = CMP_W'(radix);

	always_comb begin
		rad_clamp = rad_ext;
		if (rad_ext < CMP_W'(2))
			rad_clamp = CMP_W'(2);
		if (rad_ext > CMP_W'(MAX_RADIX))
			rad_clamp = CMP_W'(MAX_RADIX);
	end

	// one chunk of restoring division by a small divisor
	always_comb begin
		logic [TRY_W-1:0]    r;
		logic [DIV_STEP-1:0] top;
		logic [DIV_STEP-1:0] qb;
		r   = TRY_W'(rem_q);
		top = mag_q[MAG_W-1 -: DIV_STEP];
		qb  = '0;
		for (int j = DIV_STEP - 1; j >= 0; j--) begin
			r = {r[REM_W-1:0], top[j]};
			if (r >= eff_q) begin
				r     = r - eff_q;
				qb[j] = 1'b1;
			end
		end
		rem_nxt = r[REM_W-1:0];
		mag_nxt = (mag_q << DIV_STEP) | MAG_W'(qb);
	end

	assign out_free = !valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= MAG_W'(abs_val);
			neg_q <= value[VALUE_BITS-1];
			eff_q <= rad_clamp[TRY_W-1:0];
			rem_q <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_nxt;
			rem_q <= cmd.push ? '0 : rem_nxt;
		end
	end

	// digit stack, top at index 0
	always_ff @(posedge clk) begin
		if (cmd.step && cmd.push) begin
			dig_q[0] <= rem_nxt;
			for (int i = 1; i < VALUE_BITS; i++)
				dig_q[i] <= dig_q[i-1];
		end else if (cmd.emit_digit) begin
			for (int i = 0; i < VALUE_BITS - 1; i++)
				dig_q[i] <= dig_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step && cmd.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.emit_digit) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign dig_ext = (REM_W + 4)'(dig_q[0]);

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= MINUS_SIGN;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sym_of(symbols, dig_ext[3:0]);
			last_q <= (cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign status.quot_zero  = (mag_nxt == '0);
	assign status.neg        = neg_q;
	assign status.last_digit = (cnt_q == CNT_W'(1));
	assign status.out_free   = out_free;

	assign character    = char_q;
	assign last         = last_q;
	assign result_valid = valid_q;

endmodule

/* rtl/core/itr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_ctrl
// Controller: sequences load, chunked division per digit and emission.
// ----------------------------------------------------------------------------
module itr_ctrl
	import itr_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        value_valid,
	output logic        value_ready,
	input  itr_status_t status,
	output itr_cmd_t    cmd
);

	localparam int N_CHUNK = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int CH_W    = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_SIGN  = 4'b0100,
		ST_DIGIT = 4'b1000
	} state_t;

	state_t          state_q;
	state_t          state_nxt;
	logic [CH_W-1:0] chunk_q;
	logic [CH_W-1:0] chunk_nxt;
	logic            chunk_end;

	assign chunk_end   = (chunk_q == CH_W'(N_CHUNK - 1));
	assign value_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		chunk_nxt = chunk_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (value_valid) begin
					cmd.load  = 1'b1;
					chunk_nxt = '0;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (chunk_end) begin
					cmd.push  = 1'b1;
					chunk_nxt = '0;
					if (status.quot_zero)
						state_nxt = status.neg ? ST_SIGN : ST_DIGIT;
				end else begin
					chunk_nxt = chunk_q + CH_W'(1);
				end
			end
			ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_nxt     = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit)
						state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
		end else begin
			state_q <= state_nxt;
			chunk_q <= chunk_nxt;
		end
	end

endmodule

/* rtl/core/int_to_radix_string.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_radix_string
// Signed integer to text in radix 2..MAX_RADIX, one character per transaction,
// most significant digit first, optional leading minus sign.
// ----------------------------------------------------------------------------
// Operation: each digit takes ceil(VALUE_BITS/8) chunks of long division (4 at
//   32 bits), one 8-bit chunk per cycle, then the characters go one by one
//   into the output register, which stalls while it holds an unaccepted character.
// Input: a new value is taken only in idle, once the last character of the
//   previous value is in the output register; a minus sign precedes the digits.
// Reset: asynchronous; radix returns to 10 and symbols to "0123456789abcdef".
// ----------------------------------------------------------------------------
module int_to_radix_string
	import itr_pkg::*;
#(
	parameter int MAX_RADIX  = MAX_RADIX_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	output logic [PDATA_W-1:0]           prdata,
	output logic                         pready,
	input  logic                         value_valid,
	output logic                         value_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [7:0]                   character,
	output logic                         last
);

	logic [RADIX_W-1:0] radix;
	sym_tab_t           symbols;
	itr_cmd_t           cmd;
	itr_status_t        status;

	itr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.radix   (radix),
		.symbols (symbols)
	);

	itr_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.status      (status),
		.cmd         (cmd)
	);

	itr_dp #(
		.MAX_RADIX  (MAX_RADIX),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.radix        (radix),
		.symbols      (symbols),
		.character    (character),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
